FILE: src/cbp_pkg.sv
`timescale 1ns / 1ps
package cbp_pkg;

   typedef enum logic [1:0] {
      PH_HEAD = 2'd0,
      PH_ARG  = 2'd1,
      PH_STR  = 2'd2,
      PH_DONE = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      FSM_IDLE = 2'd0,
      FSM_READ = 2'd1,
      FSM_EVAL = 2'd2
   } fsm_type;

   typedef enum logic [2:0] {
      ST_BUSY      = 3'd0,
      ST_COMPLETE  = 3'd1,
      ST_MALFORMED = 3'd2,
      ST_TRUNCATED = 3'd3,
      ST_TOO_DEEP  = 3'd4
   } status_type;

   localparam logic [2:0] MAJ_BSTR  = 3'd2;
   localparam logic [2:0] MAJ_TSTR  = 3'd3;
   localparam logic [2:0] MAJ_ARRAY = 3'd4;
   localparam logic [2:0] MAJ_MAP   = 3'd5;
   localparam logic [2:0] MAJ_TAG   = 3'd6;

   localparam logic [4:0] AI_ONE_BYTE = 5'd24;
   localparam logic [4:0] AI_MAX_LEN  = 5'd27;
   localparam logic [4:0] DEPTH_RESET = 5'd16;

   // stack entry: children left, awaiting map value, level is map
   typedef struct packed {
      logic [63:0] children;
      logic        awaiting;
      logic        is_map;
   } entry_type;

endpackage

FILE: src/cbor_item_boundary_parser.sv
`timescale 1ns / 1ps
// A byte that needs no stack walk has its result registered directly; a byte that closes levels
// first walks the stack, with a read state then an evaluate state for each level visited.
// Throughput: one request at a time; the next is taken once the result is taken.
// The stack lives in a RAM with a single write port and a registered read.
// Synchronous active-high reset clears control state; the stack RAM is not cleared.
module cbor_item_boundary_parser #(
   parameter int NEST_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic        rsp_head_done,
   output logic [2:0]  rsp_head_major,
   output logic [63:0] rsp_head_argument,
   output logic [4:0]  rsp_nesting_level,
   input  logic        csr_wr_en,
   input  logic [4:0]  csr_wr_data
);
   import cbp_pkg::*;

   localparam int AW = NEST_DEPTH > 1 ? $clog2(NEST_DEPTH) : 1;
   localparam int LW = $clog2(NEST_DEPTH + 1);

   fsm_type        fsm_ff, fsm_in;
   phase_type      phase_ff, phase_in;
   logic [63:0]    acc_ff, acc_in;
   logic [3:0]     argl_ff, argl_in;
   logic [2:0]     hmaj_ff, hmaj_in;
   logic [63:0]    strl_ff, strl_in;
   logic [LW-1:0]  lvl_ff, lvl_in;
   logic [2:0]     err_ff, err_in;
   logic [4:0]     dl_ff;
   logic           last_ff, last_in;
   logic           hd_ff, hd_in;
   logic [2:0]     hm_ff, hm_in;
   logic [63:0]    ha_ff, ha_in;
   logic           rv_ff, rv_in;
   logic [2:0]     rst_ff, rst_in;
   logic           rhd_ff;
   logic [2:0]     rhm_ff;
   logic [63:0]    rha_ff;
   logic [LW-1:0]  rlvl_ff;

   logic           accept, finish, walk;
   logic [2:0]     fin_st, st;
   logic           wr_en;
   logic [AW-1:0]  wr_addr, rd_addr;
   entry_type      wr_data, rd_data;
   logic [LW-1:0]  top;

   // per-request scratch
   logic [LW-1:0]  lvl;
   logic [4:0]     ai;
   logic           hc, idn;
   logic [2:0]     hc_m;
   logic [63:0]    hc_a, cnt;

   assign req_stall = !(fsm_ff == FSM_IDLE && (!rv_ff || !rsp_stall));
   assign accept    = req_valid && !req_stall;
   assign top       = lvl_ff - LW'(1);
   assign rd_addr   = top[AW-1:0];

   cbp_ram #(.WIDTH($bits(entry_type)), .DEPTH(NEST_DEPTH)) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      argl_in  = argl_ff;
      hmaj_in  = hmaj_ff;
      strl_in  = strl_ff;
      lvl_in   = lvl_ff;
      err_in   = err_ff;
      last_in  = last_ff;
      hd_in    = hd_ff;
      hm_in    = hm_ff;
      ha_in    = ha_ff;
      finish   = 1'b0;
      walk     = 1'b0;
      st       = ST_BUSY;
      wr_en    = 1'b0;
      wr_addr  = lvl_ff[AW-1:0];
      wr_data  = rd_data;
      lvl      = lvl_ff;
      ai       = req_data_byte[4:0];
      hc       = 1'b0;
      idn      = 1'b0;
      hc_m     = hmaj_ff;
      hc_a     = 64'd0;
      cnt      = rd_data.children - 64'd1;
      if (fsm_ff == FSM_IDLE && accept) begin
         last_in = req_last;
         hd_in   = 1'b0;
         hm_in   = 3'd0;
         ha_in   = 64'd0;
         if (req_first) begin
            phase_in = PH_HEAD;
            acc_in   = 64'd0;
            argl_in  = 4'd0;
            hmaj_in  = 3'd0;
            strl_in  = 64'd0;
            lvl_in   = '0;
            err_in   = ST_BUSY;
            lvl      = '0;
         end
         if (err_in != ST_BUSY) begin
            finish = 1'b1;
            st     = err_in;
         end else if (phase_in == PH_DONE) begin
            finish = 1'b1;
            st     = ST_COMPLETE;
         end else begin
            case (phase_in)
               PH_HEAD: begin
                  if (ai < AI_ONE_BYTE) begin
                     hc   = 1'b1;
                     hc_m = req_data_byte[7:5];
                     hc_a = {59'd0, ai};
                  end else if (ai <= AI_MAX_LEN) begin
                     hmaj_in  = req_data_byte[7:5];
                     acc_in   = 64'd0;
                     argl_in  = 4'd1 << ai[1:0];
                     phase_in = PH_ARG;
                  end else begin
                     st = ST_MALFORMED;
                  end
               end
               PH_ARG: begin
                  acc_in  = {acc_ff[55:0], req_data_byte};
                  argl_in = (argl_ff != 4'd0) ? argl_ff - 4'd1 : argl_ff;
                  if (argl_in == 4'd0) begin
                     hc   = 1'b1;
                     hc_m = hmaj_ff;
                     hc_a = acc_in;
                  end
               end
               default: begin
                  strl_in = (strl_ff != 64'd0) ? strl_ff - 64'd1 : strl_ff;
                  if (strl_in == 64'd0) begin
                     phase_in = PH_HEAD;
                     idn      = 1'b1;
                  end
               end
            endcase
            if (hc) begin
               hd_in    = 1'b1;
               hm_in    = hc_m;
               ha_in    = hc_a;
               phase_in = PH_HEAD;
               if (hc_m == MAJ_BSTR || hc_m == MAJ_TSTR) begin
                  if (hc_a == 64'd0) begin
                     idn = 1'b1;
                  end else begin
                     strl_in  = hc_a;
                     phase_in = PH_STR;
                  end
               end else if (hc_m == MAJ_ARRAY || hc_m == MAJ_MAP || hc_m == MAJ_TAG) begin
                  if (hc_m != MAJ_TAG && hc_a == 64'd0) begin
                     idn = 1'b1;
                  end else if (int'(lvl) >= int'(dl_ff) || int'(lvl) >= NEST_DEPTH) begin
                     st = ST_TOO_DEEP;
                  end else begin
                     wr_en            = 1'b1;
                     wr_addr          = lvl[AW-1:0];
                     wr_data.children = (hc_m == MAJ_TAG) ? 64'd1 : hc_a;
                     wr_data.awaiting = 1'b0;
                     wr_data.is_map   = (hc_m == MAJ_MAP);
                     lvl_in           = lvl + LW'(1);
                  end
               end else begin
                  idn = 1'b1;
               end
            end
            if (idn) begin
               if (lvl == '0) begin
                  phase_in = PH_DONE;
                  st       = ST_COMPLETE;
               end else begin
                  walk = 1'b1;
               end
            end
            finish = !walk;
         end
      end else if (fsm_ff == FSM_EVAL) begin
         wr_addr = top[AW-1:0];
         if (rd_data.is_map && !rd_data.awaiting) begin
            wr_en            = 1'b1;
            wr_data.awaiting = 1'b1;
            finish           = 1'b1;
         end else if (cnt != 64'd0) begin
            wr_en            = 1'b1;
            wr_data.children = cnt;
            wr_data.awaiting = 1'b0;
            finish           = 1'b1;
         end else begin
            lvl_in = top;
            if (top == '0) begin
               phase_in = PH_DONE;
               st       = ST_COMPLETE;
               finish   = 1'b1;
            end else begin
               walk = 1'b1;
            end
         end
      end
      fin_st = (st == ST_BUSY && last_in) ? ST_TRUNCATED : st;
      if (finish && fin_st >= ST_MALFORMED) begin
         err_in = fin_st;
      end
   end

   always_comb begin
      fsm_in = fsm_ff;
      case (fsm_ff)
         FSM_IDLE: if (walk) fsm_in = FSM_READ;
         FSM_READ: fsm_in = FSM_EVAL;
         FSM_EVAL: fsm_in = walk ? FSM_READ : FSM_IDLE;
         default:  fsm_in = FSM_IDLE;
      endcase
   end

   always_comb begin
      rv_in  = rv_ff && rsp_stall;
      rst_in = rst_ff;
      if (finish) begin
         rv_in  = 1'b1;
         rst_in = fin_st;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff   <= FSM_IDLE;
         phase_ff <= PH_HEAD;
         acc_ff   <= 64'd0;
         argl_ff  <= 4'd0;
         hmaj_ff  <= 3'd0;
         strl_ff  <= 64'd0;
         lvl_ff   <= '0;
         err_ff   <= ST_BUSY;
         dl_ff    <= DEPTH_RESET;
         rv_ff    <= 1'b0;
      end else begin
         fsm_ff   <= fsm_in;
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         argl_ff  <= argl_in;
         hmaj_ff  <= hmaj_in;
         strl_ff  <= strl_in;
         lvl_ff   <= lvl_in;
         err_ff   <= err_in;
         rv_ff    <= rv_in;
         if (csr_wr_en) begin
            dl_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      last_ff <= last_in;
      hd_ff   <= hd_in;
      hm_ff   <= hm_in;
      ha_ff   <= ha_in;
      rst_ff  <= rst_in;
      if (finish) begin
         rhd_ff  <= hd_in;
         rhm_ff  <= hm_in;
         rha_ff  <= ha_in;
         rlvl_ff <= lvl_in;
      end
   end

   assign rsp_valid         = rv_ff;
   assign rsp_status        = rst_ff;
   assign rsp_head_done     = rhd_ff;
   assign rsp_head_major    = rhm_ff;
   assign rsp_head_argument = rha_ff;
   assign rsp_nesting_level = 5'(rlvl_ff);

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      int'(lvl_ff) <= NEST_DEPTH) else $error("stack level beyond depth");

   a_eval_after_read: assert property (@(posedge clock) disable iff (reset)
      fsm_ff == FSM_EVAL |-> $past(fsm_ff) == FSM_READ)
      else $error("evaluate without prior read");

   a_walk_nonempty: assert property (@(posedge clock) disable iff (reset)
      fsm_ff != FSM_IDLE |-> lvl_ff != '0) else $error("walk on empty stack");

   a_no_head_no_arg: assert property (@(posedge clock) disable iff (reset)
      rv_ff && !rhd_ff |-> rha_ff == 64'd0 && rhm_ff == 3'd0)
      else $error("argument reported without head");
endmodule

FILE: src/cbp_ram.sv
`timescale 1ns / 1ps
module cbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
